// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the vertex projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after a trigger, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vpp_pkg.sv =====
// Package with types, constants and helpers of the vertex projection block.
package vpp_pkg;

   localparam int IMAGE_SIZE_DEFAULT = 160;
   localparam int NUM_REGS           = 8;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 64;

   // Number of Q16.16 fraction bits carried by every fixed-point value.
   localparam int FRAC_BITS = 16;

   // Width of a divide numerator and of a quotient.
   localparam int NUM_W  = 49;
   localparam int QUOT_W = 64;

   // Magnitude limits of the two divide kinds.
   localparam logic [QUOT_W-1:0] CAM_LIMIT    = 64'h0000_0000_8000_0000;
   localparam logic [QUOT_W-1:0] SCREEN_LIMIT = 64'h0000_8000_0000_0000;

   typedef logic [CSR_DATA_W-1:0] csr_word_type;
   typedef logic signed [31:0]    q16_type;

   // Reset values of the matrix registers: the identity.
   localparam csr_word_type MATRIX_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0,
      64'h0001_0000_0000_0000, 64'h0,
      64'h0,                   64'h0000_0000_0001_0000,
      64'h0,                   64'h0001_0000_0000_0000
   };

   // Word moved on the request channel.
   typedef struct packed {
      q16_type world_x;
      q16_type world_y;
      q16_type world_z;
   } req_word_type;

   // Word moved on the result channel.
   typedef struct packed {
      logic signed [15:0] raster_x;
      logic signed [15:0] raster_y;
      q16_type            camera_x;
      q16_type            camera_y;
      q16_type            camera_z;
      logic               divide_fault;
   } rsp_word_type;

   // Clamps a 64-bit signed value into 32 bits.
   function automatic q16_type sat32(input logic signed [63:0] v);
      logic signed [63:0] lo;
      logic signed [63:0] hi;
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
      if (v < lo) sat32 = q16_type'(lo);
      else if (v > hi) sat32 = q16_type'(hi);
      else sat32 = v[31:0];
   endfunction

   // Clamps a 64-bit signed value into 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v < -64'sd32768) sat16 = 16'sh8000;
      else if (v > 64'sd32767) sat16 = 16'sh7fff;
      else sat16 = v[15:0];
   endfunction

endpackage

// ===== rtl/vpp_stream_if.sv =====
// Valid/ready stream interface carrying one word of a given type.
interface vpp_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vpp_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, magnitude clamp.
module vpp_divider #(
   parameter int DW = 32,
   parameter int QW = 64
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [vpp_pkg::NUM_W-1:0]   num_mag,
   input  logic [DW-1:0]               den_mag,
   input  logic [QW-1:0]               limit,
   output logic [QW-1:0]               quot
);
   import vpp_pkg::*;

   // The dividend is num_mag shifted up by the fraction bits.
   localparam int NW = NUM_W + FRAC_BITS;
   localparam int RW = DW + 1;

   logic [RW-1:0] rem_ff  [NW+1];
   logic [NW-1:0] quo_ff  [NW+1];
   logic [NW-1:0] dvd_ff  [NW+1];
   logic [DW-1:0] den_ff  [NW+1];
   logic [QW-1:0] lim_ff  [NW+1];

   // Stage zero loads the operands. A zero numerator gives a zero quotient
   // whatever the divisor, so it is divided by one.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         dvd_ff[0] <= {num_mag, {FRAC_BITS{1'b0}}};
         den_ff[0] <= (num_mag == '0) ? DW'(1) : den_mag;
         lim_ff[0] <= limit;
      end
   end

   // Each stage brings down one dividend bit and develops one quotient bit.
   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [RW:0]   trial;
      logic [RW-1:0] rem_in;
      logic          bit_in;
      always_comb begin
         trial  = {rem_ff[s], dvd_ff[s][NW-1-s]} - {2'b00, den_ff[s]};
         bit_in = ~trial[RW];
         rem_in = bit_in ? trial[RW-1:0] : {rem_ff[s][RW-2:0], dvd_ff[s][NW-1-s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= rem_in;
            quo_ff[s+1] <= {quo_ff[s][NW-2:0], bit_in};
            dvd_ff[s+1] <= dvd_ff[s];
            den_ff[s+1] <= den_ff[s];
            lim_ff[s+1] <= lim_ff[s];
         end
      end
   end

   // A zero divisor yields all ones here, which the clamp turns into the limit.
   always_comb begin
      logic [QW-1:0] q;
      q = QW'(quo_ff[NW]);
      quot = (q > lim_ff[NW]) ? lim_ff[NW] : q;
   end
endmodule

// ===== rtl/vertex_perspective_project.sv =====
// Vertex perspective projection: matrix transform, w divide, z divide, raster map.
//
// One vertex enters per clock and one result leaves per clock while the
// result side does not stall. The pipeline runs through the three matrix
// multiply stages, the first divider pipeline, one camera stage, the second
// divider pipeline and the two raster mapping stages; each divider pipeline
// has 66 stages: an operand load stage and 65 stages of one quotient bit. A
// stall on the result side freezes the whole pipeline; nothing is lost.
module vertex_perspective_project #(
   parameter int IMAGE_SIZE = vpp_pkg::IMAGE_SIZE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   vpp_stream_if.sink                        req,
   vpp_stream_if.source                      rsp,
   input  logic                              csr_write,
   input  logic [vpp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vpp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import vpp_pkg::*;
   `include "assert_macros.svh"

   localparam int NW  = NUM_W + FRAC_BITS;
   localparam int DIV_LAT = NW + 1;
   // Stages: products, sums, magnitudes, div1, camera/prep, div2, raster mul, out.
   localparam int LAT = 3 + DIV_LAT + 1 + DIV_LAT + 2;

   // Configuration registers.
   csr_word_type regs_ff [NUM_REGS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= MATRIX_RESET[i];
      end else if (csr_write) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   function automatic logic signed [63:0] ent(input int r, input int c);
      csr_word_type w;
      w = regs_ff[r*2 + c/2];
      ent = (c % 2 == 1) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
   endfunction

   // Pipeline flow: the whole pipe advances unless the output is held.
   logic advance;
   logic [LAT-1:0] vld_ff;
   assign advance = ~rsp.valid | rsp.ready;
   assign req.ready = advance;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-2:0], req.valid};
   end
   assign rsp.valid = vld_ff[LAT-1];

   // Stage 1: twelve products, each truncated toward zero to Q16.16.
   logic signed [63:0] prod_ff [3][4];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 3; i++) begin
               logic signed [63:0] v, p;
               v = (i == 0) ? 64'(req.data.world_x) :
                   (i == 1) ? 64'(req.data.world_y) : 64'(req.data.world_z);
               p = v * ent(i, c);
               prod_ff[i][c] <= (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
            end
         end
      end
   end

   // Stage 2: column sums a, b, c and w.
   logic signed [49:0] col_ff [4];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 4; c++)
            col_ff[c] <= 50'(ent(3, c) + prod_ff[0][c] + prod_ff[1][c] + prod_ff[2][c]);
      end
   end

   // Stage 3: magnitudes and signs for the w divide.
   logic [NUM_W-1:0] n1_ff [3];
   logic [NUM_W-1:0] w_mag_ff;
   logic             n1_neg_ff [3];
   logic             n1_zero_ff [3];
   logic             w_neg_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            n1_ff[c]      <= NUM_W'(col_ff[c][49] ? -col_ff[c] : col_ff[c]);
            n1_neg_ff[c]  <= col_ff[c][49];
            n1_zero_ff[c] <= (col_ff[c] == '0);
         end
         w_mag_ff <= NUM_W'(col_ff[3][49] ? -col_ff[3] : col_ff[3]);
         w_neg_ff <= col_ff[3][49];
      end
   end

   logic [QUOT_W-1:0] q1 [3];
   for (genvar c = 0; c < 3; c++) begin : g_div1
      vpp_divider #(.DW(NUM_W), .QW(QUOT_W)) u_div (
         .clock, .advance,
         .num_mag(n1_ff[c]), .den_mag(w_mag_ff), .limit(CAM_LIMIT),
         .quot(q1[c]));
   end

   // Sign and fault info travel alongside the first divider.
   logic [4:0] sg1_ff [DIV_LAT];
   always_ff @(posedge clock) begin
      if (advance) begin
         sg1_ff[0] <= {w_mag_ff == '0,
                       (n1_neg_ff[2] != w_neg_ff) & ~n1_zero_ff[2],
                       (n1_neg_ff[1] != w_neg_ff) & ~n1_zero_ff[1],
                       (n1_neg_ff[0] != w_neg_ff) & ~n1_zero_ff[0], 1'b0};
         for (int s = 1; s < DIV_LAT; s++) sg1_ff[s] <= sg1_ff[s-1];
      end
   end

   // Stage after div1: camera values, saturated, and operands of the z divide.
   q16_type          cam_ff [3];
   logic             f1_ff;
   logic [NUM_W-1:0] n2_ff [2];
   logic [NUM_W-1:0] z_mag_ff;
   logic             sneg_ff [2];
   always_ff @(posedge clock) begin
      if (advance) begin
         q16_type cv [3];
         for (int c = 0; c < 3; c++) begin
            logic signed [63:0] sv;
            sv = sg1_ff[DIV_LAT-1][c+1] ? -signed'(q1[c]) : signed'(q1[c]);
            cv[c] = sat32(sv);
            cam_ff[c] <= cv[c];
         end
         f1_ff <= sg1_ff[DIV_LAT-1][4];
         for (int c = 0; c < 2; c++) begin
            n2_ff[c]   <= NUM_W'(cv[c][31] ? -64'(cv[c]) : 64'(cv[c]));
            // Divisor is -z, which is negative exactly when z is positive.
            sneg_ff[c] <= cv[c][31] != (cv[2] > 0);
         end
         z_mag_ff <= NUM_W'(cv[2][31] ? -64'(cv[2]) : 64'(cv[2]));
      end
   end

   logic [QUOT_W-1:0] q2 [2];
   for (genvar c = 0; c < 2; c++) begin : g_div2
      vpp_divider #(.DW(NUM_W), .QW(QUOT_W)) u_div (
         .clock, .advance,
         .num_mag(n2_ff[c]), .den_mag(z_mag_ff), .limit(SCREEN_LIMIT),
         .quot(q2[c]));
   end

   // Camera values and fault travel alongside the second divider.
   logic [99:0] sg2_ff [DIV_LAT];
   always_ff @(posedge clock) begin
      if (advance) begin
         sg2_ff[0] <= {f1_ff | (z_mag_ff == '0), sneg_ff[1], sneg_ff[0],
                       cam_ff[0], cam_ff[1], cam_ff[2], 1'b0};
         for (int s = 1; s < DIV_LAT; s++) sg2_ff[s] <= sg2_ff[s-1];
      end
   end

   // Raster multiply stage.
   logic signed [63:0] rxp_ff, ryp_ff;
   logic [99:0]        sg3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [63:0] sx, sy;
         logic [99:0] t;
         t  = sg2_ff[DIV_LAT-1];
         sx = t[97] ? -signed'(q2[0]) : signed'(q2[0]);
         sy = t[98] ? -signed'(q2[1]) : signed'(q2[1]);
         rxp_ff <= (sx + 64'sd65536) * 64'(IMAGE_SIZE);
         ryp_ff <= (64'sd65536 - sy) * 64'(IMAGE_SIZE);
         sg3_ff <= t;
      end
   end

   // Output register: truncating divide by 2^17 and 16-bit saturation.
   rsp_word_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [63:0] rx, ry;
         rx = (rxp_ff < 0) ? -((-rxp_ff) >>> 17) : (rxp_ff >>> 17);
         ry = (ryp_ff < 0) ? -((-ryp_ff) >>> 17) : (ryp_ff >>> 17);
         out_ff.raster_x     <= sat16(rx);
         out_ff.raster_y     <= sat16(ry);
         out_ff.camera_x     <= sg3_ff[96:65];
         out_ff.camera_y     <= sg3_ff[64:33];
         out_ff.camera_z     <= sg3_ff[32:1];
         out_ff.divide_fault <= sg3_ff[99];
      end
   end
   assign rsp.data = out_ff;

   // A held result stays valid, and the pipe does not move under a stall.
   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
   `ASSERT_IMPLY(a_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready, "accept on stall")
endmodule
